>>> rtl/core/scl_pkg.sv
// Shared types and constants for the bilinear image scaler.
// No dependencies; imported by scl_blend, the top level, the checker and the bench.
package scl_pkg;

  localparam int POS_W      = 12;
  localparam int PIX_W      = 32;
  localparam int STEP_W     = 24;
  localparam int ORG_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CMP_W      = 13;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_RESAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERP_MODE = 3'd0,
    REG_ORIGIN_X    = 3'd1,
    REG_ORIGIN_Y    = 3'd2,
    REG_LAST_COL    = 3'd3,
    REG_LAST_ROW    = 3'd4,
    REG_STEP_X      = 3'd5,
    REG_STEP_Y      = 3'd6
  } reg_idx_t;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } mode_t;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             range_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_HORZ,
    ST_VERT,
    ST_RES
  } state_t;

endpackage

>>> rtl/core/scl_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// Depends on nothing.
module scl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/core/scl_blend.sv
// Per-lane separable bilinear blend: horizontal stage registered, vertical
// stage combinational from it. Depends on scl_pkg.
module scl_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       h_en,
  input  logic [scl_pkg::PIX_W-1:0]  p00,
  input  logic [scl_pkg::PIX_W-1:0]  p10,
  input  logic [scl_pkg::PIX_W-1:0]  p01,
  input  logic [scl_pkg::PIX_W-1:0]  p11,
  input  logic [FRAC_BITS-1:0]       u,
  input  logic [FRAC_BITS-1:0]       v,
  output logic [scl_pkg::PIX_W-1:0]  pix
);
  import scl_pkg::*;

  localparam int HW = 8 + FRAC_BITS;
  localparam int VW = 8 + 2 * FRAC_BITS;
  localparam logic [FRAC_BITS:0] S_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic [FRAC_BITS:0] su;
  logic [FRAC_BITS:0] sv;
  logic [HW-1:0]      top_nxt [4];
  logic [HW-1:0]      bot_nxt [4];
  logic [HW-1:0]      top_r   [4];
  logic [HW-1:0]      bot_r   [4];
  logic [FRAC_BITS-1:0] v_r;
  logic [VW-1:0]      acc     [4];

  assign su = S_ONE - {1'b0, u};
  assign sv = S_ONE - {1'b0, v_r};

  // horizontal: lane = p_left*(S-u) + p_right*u, at most 255*S
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      top_nxt[l] = HW'(p00[8*l +: 8]) * HW'(su) + HW'(p10[8*l +: 8]) * HW'(u);
      bot_nxt[l] = HW'(p01[8*l +: 8]) * HW'(su) + HW'(p11[8*l +: 8]) * HW'(u);
    end
  end

  always_ff @(posedge clk) begin
    if (h_en) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      v_r   <= v;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      acc[l]       = VW'(top_r[l]) * VW'(sv) + VW'(bot_r[l]) * VW'(v_r);
      pix[8*l +: 8] = acc[l][VW-1 -: 8];
    end
  end

endmodule

>>> rtl/core/bilinear_image_scaler.sv
// Bilinear image scaler: top level with sequencer, coordinate mapping and
// output register. Depends on scl_pkg, scl_ram and scl_blend.
//
// Usage: load a source frame with write items (operation 0, pixel at
// pos_x/pos_y), then send resample items (operation 1) naming destination
// coordinates. Each item gives exactly one result item on the out_ channel.
// Configuration (cfg_we/cfg_index/cfg_wdata) must be written only while
// idle; the user is bound to this, the block itself does not enforce it.
//
// A write item goes from idle straight to the result state. A resample
// passes the map and address states and, unless its source is out of range,
// the read states ST_RD0 and ST_RD1; in bilinear mode the horizontal and
// vertical blend states follow before the result state.
// The result shows on out_valid in the same cycle the sequencer is back in
// idle and can accept the next item.
// One item is in work at a time; the frame store has two read ports (two
// reads per cycle), so the four neighbors are read across ST_RD0 and ST_RD1.
// Reset clears the sequencer and output valid, presets the config registers;
// the frame store is not cleared and must be written before it is read.
// While out_stall holds a waiting result, the next result stays in its final
// state and in_stall stays high.
module bilinear_image_scaler #(
  parameter int SRC_WIDTH  = 256,
  parameter int SRC_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  scl_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output scl_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [scl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import scl_pkg::*;

  localparam int XW    = $clog2(SRC_WIDTH);
  localparam int YW    = $clog2(SRC_HEIGHT);
  localparam int DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = POS_W + STEP_W;   // product width
  localparam int FXW   = PW + 1;           // source position width
  localparam int IXW   = FXW - FRAC_BITS;  // integer part width

  // config registers
  logic              mode_r;
  logic [ORG_W-1:0]  origin_x_r, origin_y_r, last_col_r, last_row_r;
  logic [STEP_W-1:0] step_x_r, step_y_r;

  // sequencer
  state_t state_r, state_nxt;

  // item and datapath registers
  in_item_t           item_r;
  logic [PW-1:0]      prod_x_r, prod_y_r;
  logic [XW-1:0]      ix_r;
  logic [YW-1:0]      iy_r;
  logic [FRAC_BITS-1:0] u_r, v_r;
  logic               err_r;
  logic [PIX_W-1:0]   p00_r, p10_r;
  logic [PIX_W-1:0]   res_pix_r;
  logic               res_err_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // combinational
  logic               in_acc, out_load, wr_in_range;
  logic [FXW-1:0]     fx, fy;
  logic [IXW-1:0]     ix_full, iy_full;
  logic               pos_err;
  logic [CMP_W-1:0]   x1_ext, y1_ext;
  logic [XW-1:0]      x1;
  logic [YW-1:0]      y1;
  logic               ram_we;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic [PIX_W-1:0]   rdata_a, rdata_b;
  logic               h_en;
  logic [PIX_W-1:0]   blend_pix;

  function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] row,
                                             input logic [XW-1:0] col);
    return AW'(row) * AW'(SRC_WIDTH) + AW'(col);
  endfunction

  // ---------------- config port ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BILINEAR;
      origin_x_r <= '0;
      origin_y_r <= '0;
      last_col_r <= ORG_W'(255);
      last_row_r <= ORG_W'(255);
      step_x_r   <= STEP_W'(65536);
      step_y_r   <= STEP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERP_MODE: mode_r     <= cfg_wdata[0];
        REG_ORIGIN_X:    origin_x_r <= cfg_wdata[ORG_W-1:0];
        REG_ORIGIN_Y:    origin_y_r <= cfg_wdata[ORG_W-1:0];
        REG_LAST_COL:    last_col_r <= cfg_wdata[ORG_W-1:0];
        REG_LAST_ROW:    last_row_r <= cfg_wdata[ORG_W-1:0];
        REG_STEP_X:      step_x_r   <= cfg_wdata[STEP_W-1:0];
        REG_STEP_Y:      step_y_r   <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- mapping ----------------
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign wr_in_range = (CMP_W'(in_data.pos_x) < CMP_W'(SRC_WIDTH)) &&
                       (CMP_W'(in_data.pos_y) < CMP_W'(SRC_HEIGHT));

  assign fx      = FXW'(prod_x_r) + (FXW'(origin_x_r) << FRAC_BITS);
  assign fy      = FXW'(prod_y_r) + (FXW'(origin_y_r) << FRAC_BITS);
  assign ix_full = fx[FXW-1:FRAC_BITS];
  assign iy_full = fy[FXW-1:FRAC_BITS];
  assign pos_err = (ix_full >= IXW'(SRC_WIDTH)) || (iy_full >= IXW'(SRC_HEIGHT));

  // neighbor clamp at last_col/last_row and at the store edge
  always_comb begin
    x1_ext = CMP_W'(ix_r) + CMP_W'(1);
    y1_ext = CMP_W'(iy_r) + CMP_W'(1);
    if (x1_ext > CMP_W'(last_col_r) || x1_ext >= CMP_W'(SRC_WIDTH)) begin
      x1 = ix_r;
    end else begin
      x1 = x1_ext[XW-1:0];
    end
    if (y1_ext > CMP_W'(last_row_r) || y1_ext >= CMP_W'(SRC_HEIGHT)) begin
      y1 = iy_r;
    end else begin
      y1 = y1_ext[YW-1:0];
    end
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.operation == OP_WRITE) ? ST_RES : ST_MAP;
        end
      end
      ST_MAP:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = pos_err ? ST_RES : ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = (mode_r == MODE_NEAREST) ? ST_RES : ST_HORZ;
      ST_HORZ: state_nxt = ST_VERT;
      ST_VERT: state_nxt = ST_RES;
      ST_RES:  state_nxt = out_load ? ST_IDLE : ST_RES;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  always_comb begin
    ram_we   = 1'b0;
    waddr    = pix_addr(in_data.pos_y[YW-1:0], in_data.pos_x[XW-1:0]);
    raddr_a  = '0;
    raddr_b  = '0;
    h_en     = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: ram_we = in_acc && (in_data.operation == OP_WRITE) && wr_in_range;
      ST_RD0: begin
        raddr_a = pix_addr(iy_r, ix_r);
        raddr_b = pix_addr(iy_r, x1);
      end
      ST_RD1: begin
        raddr_a = pix_addr(y1, ix_r);
        raddr_b = pix_addr(y1, x1);
      end
      ST_HORZ: h_en = 1'b1;
      ST_RES:  out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_r    <= in_data;
          res_pix_r <= '0;
          res_err_r <= !wr_in_range;
        end
      end
      ST_MAP: begin
        prod_x_r <= PW'(item_r.pos_x) * PW'(step_x_r);
        prod_y_r <= PW'(item_r.pos_y) * PW'(step_y_r);
      end
      ST_ADDR: begin
        ix_r      <= ix_full[XW-1:0];
        iy_r      <= iy_full[YW-1:0];
        u_r       <= fx[FRAC_BITS-1:0];
        v_r       <= fy[FRAC_BITS-1:0];
        err_r     <= pos_err;
        res_pix_r <= '0;
        res_err_r <= pos_err;
      end
      ST_RD1: begin
        p00_r     <= rdata_a;
        p10_r     <= rdata_b;
        res_pix_r <= rdata_a;   // nearest result
        res_err_r <= err_r;
      end
      ST_VERT: res_pix_r <= blend_pix;
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.pixel_out   <= res_pix_r;
      out_data_r.range_error <= res_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- frame store and blend ----------------
  scl_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (waddr),
    .wdata   (in_data.pixel_in),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  scl_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk  (clk),
    .h_en (h_en),
    .p00  (p00_r),
    .p10  (p10_r),
    .p01  (rdata_a),
    .p11  (rdata_b),
    .u    (u_r),
    .v    (v_r),
    .pix  (blend_pix)
  );

endmodule

>>> rtl/core/scl_chk.sv
// Port-level checker for the bilinear image scaler, bound to the top level.
// Depends on scl_pkg and bilinear_image_scaler.
module scl_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input scl_pkg::in_item_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input scl_pkg::out_item_t  out_data
);
  import scl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  // errors carry a zero pixel
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |-> out_data.pixel_out == '0)
    else $error("range error with nonzero pixel");

  // no result appears the cycle right after an accept
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind bilinear_image_scaler scl_chk u_scl_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/bilinear_image_scaler_test.sv
// Self-checking bench for bilinear_image_scaler: loads source pixels, resamples them
// in nearest and bilinear mode under several register settings, checks every result.
// Depends on scl_pkg and the block's RTL only.
module bilinear_image_scaler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scl_pkg::*;

  localparam int W = 256;
  localparam int H = 256;
  localparam int FB = 16;
  localparam int LIMIT = 2000000;

  // Scaler predictor plus queue of pending pixels.
  class pixel_scoreboard;
    logic [31:0] frame [int];
    bit          mode;
    int unsigned org_x, org_y, lcol, lrow, stx, sty;
    out_item_t   pending[$];
    int          mismatches;
    int          checked;

    function new();
      mode = 1; org_x = 0; org_y = 0; lcol = 255; lrow = 255;
      stx = 65536; sty = 65536; mismatches = 0; checked = 0;
    endfunction

    function void set_reg(reg_idx_t idx, int unsigned val);
      case (idx)
        REG_INTERP_MODE: mode = val[0];
        REG_ORIGIN_X:    org_x = val & 8'hff;
        REG_ORIGIN_Y:    org_y = val & 8'hff;
        REG_LAST_COL:    lcol = val & 8'hff;
        REG_LAST_ROW:    lrow = val & 8'hff;
        REG_STEP_X:      stx = val & 24'hffffff;
        REG_STEP_Y:      sty = val & 24'hffffff;
        default: ;
      endcase
    endfunction

    function logic [31:0] px(longint unsigned c, longint unsigned r);
      int a;
      a = int'(r * W + c);
      return frame.exists(a) ? frame[a] : 32'h0;
    endfunction

    // Source position of a destination coordinate.
    function void map_pos(int unsigned dx, int unsigned dy,
                          output longint unsigned ix, output longint unsigned iy,
                          output longint unsigned u, output longint unsigned v);
      longint unsigned fx, fy;
      fx = longint'(dx) * stx + (longint'(org_x) << FB);
      fy = longint'(dy) * sty + (longint'(org_y) << FB);
      ix = fx >> FB; iy = fy >> FB;
      u = fx & ((64'd1 << FB) - 1); v = fy & ((64'd1 << FB) - 1);
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      longint unsigned ix, iy, u, v, x1, y1, s, acc;
      logic [31:0] p00, p10, p01, p11;
      r = '0;
      if (it.operation == OP_WRITE) begin
        if (it.pos_x >= W || it.pos_y >= H) r.range_error = 1;
        else frame[it.pos_y * W + it.pos_x] = it.pixel_in;
      end else begin
        map_pos(it.pos_x, it.pos_y, ix, iy, u, v);
        if (ix >= W || iy >= H) r.range_error = 1;
        else if (mode == MODE_NEAREST) r.pixel_out = px(ix, iy);
        else begin
          x1 = ix + 1; if (x1 > lcol || x1 >= W) x1 = ix;
          y1 = iy + 1; if (y1 > lrow || y1 >= H) y1 = iy;
          p00 = px(ix, iy); p10 = px(x1, iy); p01 = px(ix, y1); p11 = px(x1, y1);
          s = 64'd1 << FB;
          for (int l = 0; l < 4; l++) begin
            acc = longint'(p00[l*8 +: 8]) * (s - u) * (s - v)
                + longint'(p10[l*8 +: 8]) * u * (s - v)
                + longint'(p01[l*8 +: 8]) * (s - u) * v
                + longint'(p11[l*8 +: 8]) * u * v;
            r.pixel_out[l*8 +: 8] = 8'(acc >> (2 * FB));
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", got.pixel_out, got.range_error);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pixel_out !== want.pixel_out || got.range_error !== want.range_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pixel exp %h got %h, range_error exp %b got %b",
                   want.pixel_out, got.pixel_out, want.range_error, got.range_error);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_valid = 0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 0;
  out_item_t  out_data;
  logic       cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pixel_scoreboard sb = new();
  int  cycles = 0;
  int  n_resample = 0;
  bit  hold_long = 0;  // asks the receiver for one long stall
  // Source pixels written so far; random resamples only touch these.
  bit  written [int];

  always #5 clk = ~clk;

  bilinear_image_scaler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Cycle guard: a hang ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check accepted items, then pick the next stall value.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);   // long hold-off; the sender blocks once in_stall is held
        hold_long = 0;
        out_stall <= 0;
        @(posedge clk);
      end else if ($urandom_range(0, 99) < 25) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(5, 30)) @(posedge clk);  // stall-free stretch
      end else begin
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until accepted; random idle gap before it.
  task automatic send_item(op_t op, int unsigned x, int unsigned y, logic [31:0] pix,
                           bit gaps = 1);
    in_item_t it;
    int gap;
    it.operation = op; it.pos_x = 12'(x); it.pos_y = 12'(y); it.pixel_in = pix;
    if (gaps && $urandom_range(0, 99) < 30) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    if (op == OP_RESAMPLE) n_resample++;
    if (op == OP_WRITE && x < W && y < H) written[y * W + x] = 1;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);  // longest item latency plus margin
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  // Fill a source window so resamples that land in it read written pixels.
  task automatic fill(int x0, int y0, int w, int h);
    for (int y = y0; y < y0 + h; y++)
      for (int x = x0; x < x0 + w; x++)
        send_item(OP_WRITE, x, y, $urandom(), 0);
  endtask

  // A resample that only reads written pixels (neighbors included).
  function automatic bit safe_resample(int unsigned x, int unsigned y);
    longint unsigned ix, iy, u, v, x1, y1;
    sb.map_pos(x, y, ix, iy, u, v);
    if (ix >= W || iy >= H) return 1;
    if (sb.mode == MODE_NEAREST) return written.exists(int'(iy * W + ix));
    x1 = ix + 1; if (x1 > sb.lcol || x1 >= W) x1 = ix;
    y1 = iy + 1; if (y1 > sb.lrow || y1 >= H) y1 = iy;
    return written.exists(int'(iy*W+ix)) && written.exists(int'(iy*W+x1)) &&
           written.exists(int'(y1*W+ix)) && written.exists(int'(y1*W+x1));
  endfunction

  task automatic random_phase(int count, int win);
    int unsigned x, y;
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        // write, occasionally outside the store
        if ($urandom_range(0, 9) == 0) send_item(OP_WRITE, $urandom_range(0, 4095),
                                                 $urandom_range(256, 4095), $urandom());
        else send_item(OP_WRITE, $urandom_range(0, win), $urandom_range(0, win), $urandom());
        sent++;
      end else begin
        if ($urandom_range(0, 15) == 0) begin
          x = $urandom_range(0, 4095); y = $urandom_range(0, 4095);
        end else begin
          x = $urandom_range(0, 40); y = $urandom_range(0, 40);
        end
        if (safe_resample(x, y)) begin
          send_item(OP_RESAMPLE, x, y, $urandom());
          sent++;
        end
      end
      if (sent == count / 2 && !hold_long && $urandom_range(0, 1)) hold_long = 1;
    end
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: corners of the store, an out-of-store write, bit extremes.
    fill(0, 0, 4, 4);
    send_item(OP_WRITE, 255, 255, 32'hffff_ffff);
    send_item(OP_WRITE, 254, 255, 32'h0000_0000);
    send_item(OP_WRITE, 255, 254, 32'haaaa_5555);
    send_item(OP_WRITE, 254, 254, 32'h5555_aaaa);
    send_item(OP_WRITE, 4095, 4095, 32'hffff_ffff);
    send_item(OP_RESAMPLE, 0, 0, 32'hffff_ffff);       // reset step: identity
    send_item(OP_RESAMPLE, 255, 255, 0);               // clamped at both edges
    send_item(OP_RESAMPLE, 256, 0, 0);                 // source past last column
    send_item(OP_RESAMPLE, 4095, 4095, 0);
    drain();

    // Half-pixel steps with tight clamps; nearest mode too.
    write_reg(REG_STEP_X, 32768);
    write_reg(REG_STEP_Y, 32768);
    write_reg(REG_LAST_COL, 2);
    write_reg(REG_LAST_ROW, 2);
    for (int i = 0; i < 8; i++) send_item(OP_RESAMPLE, i, 7 - i, 0);
    drain();
    write_reg(REG_INTERP_MODE, MODE_NEAREST);
    for (int i = 0; i < 4; i++) send_item(OP_RESAMPLE, i, i, 0);
    drain();

    // Random phases over several register settings.
    write_reg(REG_INTERP_MODE, MODE_BILINEAR);
    write_reg(REG_LAST_COL, 255);
    write_reg(REG_LAST_ROW, 255);
    fill(0, 0, 24, 24);
    random_phase(200, 23);
    drain();

    write_reg(REG_ORIGIN_X, 250);
    write_reg(REG_ORIGIN_Y, 250);
    write_reg(REG_STEP_X, 24'hffffff);
    write_reg(REG_STEP_Y, 12345);
    fill(250, 250, 6, 6);
    hold_long = 1;
    random_phase(150, 23);
    drain();   // sender waits out every pending result here

    write_reg(REG_ORIGIN_X, 5);
    write_reg(REG_ORIGIN_Y, 3);
    write_reg(REG_STEP_X, 40000);
    write_reg(REG_STEP_Y, 0);
    write_reg(REG_LAST_COL, 10);
    write_reg(REG_LAST_ROW, 0);
    fill(24, 3, 16, 1);
    random_phase(200, 23);
    drain();

    write_reg(REG_INTERP_MODE, MODE_NEAREST);
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    write_reg(REG_STEP_X, 65536 + 21845);
    write_reg(REG_STEP_Y, 50000);
    random_phase(150, 23);
    drain();

    write_reg(REG_INTERP_MODE, MODE_BILINEAR);
    write_reg(REG_STEP_X, 30000);
    write_reg(REG_STEP_Y, 20000);
    write_reg(REG_LAST_COL, 0);
    write_reg(REG_LAST_ROW, 255);
    random_phase(200, 23);
    drain();

    $display("covered %0d results, %0d resamples, over nearest and bilinear modes",
             sb.checked, n_resample);
    $display("registers swept through edge clamps, zero and maximum steps, far origins");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/scl_pkg.sv
rtl/core/scl_ram.sv
rtl/core/scl_blend.sv
rtl/core/bilinear_image_scaler.sv
rtl/core/scl_chk.sv
bench/bilinear_image_scaler_test.sv
